// ===== hw/rtl/rle_byte_decompressor_unit_assert.svh =====
// Assertion macros for the run-length byte decompressor.
// Depends on nothing; included by the top level only.
`ifndef RLE_BYTE_DECOMPRESSOR_UNIT_ASSERT_SVH
`define RLE_BYTE_DECOMPRESSOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBD_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rbd_pkg.sv =====
// Shared constants and codes of the run-length byte decompressor.
// Depends on nothing; used by the channel interfaces and the top level.
`default_nettype none

package rbd_pkg;

  localparam int OUT_LANES = 8;
  localparam int BYTE_W    = 8;
  localparam int DATA_W    = BYTE_W * OUT_LANES;
  localparam int CNT_W     = $clog2(OUT_LANES + 1);
  localparam int LEN_W     = 32;
  localparam int RUN_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int STAT_W    = 2;
  localparam int PHASE_W   = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_PACKED_LEN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNPACKED_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED_MODE = 2'd2;

  // Decode phase
  localparam logic [PHASE_W-1:0] PH_TOKEN   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LITERAL = 2'd1;
  localparam logic [PHASE_W-1:0] PH_REPEAT  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE    = 2'd3;

  // Stream status
  localparam logic [STAT_W-1:0] ST_RUNNING = 2'd0;
  localparam logic [STAT_W-1:0] ST_OK      = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERROR   = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/rbd_if.sv =====
// Valid/ready channel interfaces: packed input bytes, decoded words, config writes.
// Depends on rbd_pkg.
`default_nettype none

interface rbd_in_if;
  import rbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              stream_start;
  logic              source_end;
  modport source (output valid, output in_byte, output stream_start, output source_end,
                  input ready);
  modport sink   (input valid, input in_byte, input stream_start, input source_end,
                  output ready);
endinterface

interface rbd_out_if;
  import rbd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]  out_count;
  logic              item_last;
  logic              stream_done;
  logic [STAT_W-1:0] stream_status;
  modport source (output valid, output out_data, output out_count, output item_last,
                  output stream_done, output stream_status, input ready);
  modport sink   (input valid, input out_data, input out_count, input item_last,
                  input stream_done, input stream_status, output ready);
endinterface

interface rbd_cfg_if;
  import rbd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEN_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rle_byte_decompressor_unit.sv =====
// Top level of the run-length byte decompressor: sequencer, counters, output register.
// Depends on rbd_pkg, the channel interfaces in rbd_if.sv and the assertion header.
`default_nettype none
`include "rle_byte_decompressor_unit_assert.svh"

// Decodes a PackBits-style stream, one packed byte per input request. A token
// below 128 opens a literal run of token+1 bytes, each passed out as it
// arrives; any other token makes the next byte repeat (token-128)+2 times,
// passed out in words of up to eight bytes, first byte in the low lane.
// Every request yields at least one result; a request that produces no byte
// yields one status-only word (out_count zero). item_last marks the last word
// of a request, and stream_done/stream_status give the stream state after it.
// The end test is made at token boundaries (packed_len consumed or
// unpacked_len written). Bytes past unpacked_len are dropped and flag an
// error, as does source_end before the stream has finished. With
// compressed_mode at zero the bytes are copied through until unpacked_len is
// reached. stream_start clears the counters before its byte is decoded.
// One request is handled at a time. After a byte is taken, states S_CALC1
// and S_CALC2 settle the remaining space and the next decode state; then
// each result word is loaded (S_LOAD) and presented (S_EMIT), and is held
// there while the output stalls. A single word-count subtractor drains a
// run lane group by lane group. Configuration writes are always taken and
// act at once.
module rle_byte_decompressor_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  rbd_in_if.sink     src,
  rbd_out_if.source  dst,
  rbd_cfg_if.sink    cfg
);
  import rbd_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC1 = 3'd1;
  localparam logic [2:0] S_CALC2 = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Configuration registers
  logic [LEN_W-1:0] packed_len;
  logic [LEN_W-1:0] unpacked_len;
  logic             compressed_mode;

  // Decode state
  logic [PHASE_W-1:0] decode_phase;
  logic [RUN_W-1:0]   run_remaining;
  logic [LEN_W-1:0]   packed_consumed;
  logic [LEN_W-1:0]   bytes_written;
  logic               error_seen;

  // Sequencer and held request
  logic [2:0]        seq;
  logic [BYTE_W-1:0] hold_byte;
  logic              hold_end;

  // Precomputed length terms
  logic [LEN_W-1:0] space;      // unpacked_len - bytes_written, floored at zero
  logic             over;       // written already past the length
  logic             full_now;   // packed bytes consumed
  logic             full_next;  // consumed after one more byte

  // Word emitter
  logic [RUN_W-1:0] emit_left;

  // Output register
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]  out_count;
  logic              out_last;

  // Decode step results
  logic [PHASE_W-1:0] phase_next;
  logic [RUN_W-1:0]   run_next;
  logic               err_next;
  logic               cons_inc;
  logic [RUN_W-1:0]   n_bytes;

  // Emitter word
  logic [CNT_W-1:0]  word_cnt;
  logic [DATA_W-1:0] word_data;
  logic              word_last;

  logic in_take;
  logic out_take;

  assign in_take  = src.valid && src.ready;
  assign out_take = dst.valid && dst.ready;

  assign src.ready = (seq == S_IDLE);
  assign cfg.ready = 1'b1;

  assign dst.valid         = out_valid;
  assign dst.out_data      = out_data;
  assign dst.out_count     = out_count;
  assign dst.item_last     = out_last;
  assign dst.stream_done   = (decode_phase == PH_DONE);
  assign dst.stream_status = (decode_phase != PH_DONE) ? ST_RUNNING :
                             (error_seen ? ST_ERROR : ST_OK);

  // Decode one byte against the precomputed space and packed-length flags.
  always_comb begin
    logic has_space;
    logic run_gt;
    logic wr_full;
    logic fin;
    logic check_end;

    has_space  = (space != '0);
    run_gt     = (space[LEN_W-1:RUN_W] == '0) && (run_remaining > space[RUN_W-1:0]);
    phase_next = decode_phase;
    run_next   = run_remaining;
    err_next   = error_seen;
    cons_inc   = 1'b0;
    n_bytes    = '0;
    fin        = 1'b0;
    check_end  = 1'b0;

    if (decode_phase != PH_DONE) begin
      if (!compressed_mode) begin
        // Bypass: copy one byte while there is room
        if (!has_space) begin
          fin = 1'b1;
        end else begin
          cons_inc  = 1'b1;
          n_bytes   = RUN_W'(1);
          check_end = 1'b1;
        end
      end else if (decode_phase == PH_TOKEN && (full_now || !has_space)) begin
        fin = 1'b1;
      end else begin
        cons_inc = 1'b1;
        unique case (decode_phase)
          PH_TOKEN: begin
            if (!hold_byte[BYTE_W-1]) begin
              phase_next = PH_LITERAL;
              run_next   = hold_byte + RUN_W'(1);
            end else begin
              phase_next = PH_REPEAT;
              run_next   = {1'b0, hold_byte[BYTE_W-2:0]} + RUN_W'(2);
            end
          end
          PH_LITERAL: begin
            if (has_space) n_bytes = RUN_W'(1);
            else err_next = 1'b1;
            if (run_remaining <= RUN_W'(1)) begin
              run_next   = '0;
              phase_next = PH_TOKEN;
            end else begin
              run_next = run_remaining - RUN_W'(1);
            end
          end
          default: begin
            // Repeat: emit as much of the run as fits, drop the rest
            if (run_gt || !has_space) begin
              n_bytes  = space[RUN_W-1:0];
              err_next = err_next || (run_remaining != '0);
            end else begin
              n_bytes = run_remaining;
            end
            run_next   = '0;
            phase_next = PH_TOKEN;
          end
        endcase
      end
    end

    // Written count reaches the length after this byte
    wr_full = over || ((space[LEN_W-1:RUN_W] == '0) && (space[RUN_W-1:0] == n_bytes));

    if (check_end && wr_full) fin = 1'b1;
    if (compressed_mode && cons_inc && phase_next == PH_TOKEN &&
        (full_next || wr_full)) fin = 1'b1;

    if (fin) begin
      phase_next = PH_DONE;
      if (!(wr_full && !over)) err_next = 1'b1;
    end

    if (phase_next != PH_DONE && hold_end) begin
      phase_next = PH_DONE;
      err_next   = 1'b1;
    end
  end

  // Next word: up to OUT_LANES copies of the held byte.
  always_comb begin
    word_last = (emit_left <= RUN_W'(OUT_LANES));
    word_cnt  = word_last ? CNT_W'(emit_left) : CNT_W'(OUT_LANES);
    for (int i = 0; i < OUT_LANES; i++) begin
      word_data[i*BYTE_W +: BYTE_W] = (CNT_W'(i) < word_cnt) ? hold_byte : '0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      packed_len      <= '0;
      unpacked_len    <= '0;
      compressed_mode <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PACKED_LEN:      packed_len      <= cfg.data;
        REG_UNPACKED_LEN:    unpacked_len    <= cfg.data;
        REG_COMPRESSED_MODE: compressed_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq             <= S_IDLE;
      decode_phase    <= PH_TOKEN;
      run_remaining   <= '0;
      packed_consumed <= '0;
      bytes_written   <= '0;
      error_seen      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      unique case (seq)
        S_IDLE: begin
          if (in_take) begin
            // Clear counters before the first byte of a stream
            if (src.stream_start) begin
              decode_phase    <= PH_TOKEN;
              run_remaining   <= '0;
              packed_consumed <= '0;
              bytes_written   <= '0;
              error_seen      <= 1'b0;
            end
            seq <= S_CALC1;
          end
        end
        S_CALC1: seq <= S_CALC2;
        S_CALC2: begin
          decode_phase  <= phase_next;
          run_remaining <= run_next;
          error_seen    <= err_next;
          bytes_written <= bytes_written + LEN_W'(n_bytes);
          if (cons_inc && packed_consumed != LEN_MAX)
            packed_consumed <= packed_consumed + LEN_W'(1);
          seq <= S_LOAD;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          seq       <= S_EMIT;
        end
        S_EMIT: begin
          // Hold the word until taken, then advance or finish the request
          if (out_take) begin
            out_valid <= 1'b0;
            seq       <= out_last ? S_IDLE : S_LOAD;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (seq == S_IDLE && in_take) begin
      hold_byte <= src.in_byte;
      hold_end  <= src.source_end;
    end
    if (seq == S_CALC1) begin
      space     <= (unpacked_len > bytes_written) ? unpacked_len - bytes_written : '0;
      over      <= (bytes_written > unpacked_len);
      full_now  <= (packed_consumed >= packed_len);
      full_next <= (packed_consumed == LEN_MAX) ? (packed_consumed >= packed_len) :
                   (({1'b0, packed_consumed} + (LEN_W+1)'(1)) >= {1'b0, packed_len});
    end
    if (seq == S_CALC2) emit_left <= n_bytes;
    if (seq == S_LOAD) begin
      out_data  <= word_data;
      out_count <= word_cnt;
      out_last  <= word_last;
      emit_left <= emit_left - RUN_W'(word_cnt);
    end
  end

  // Checks
  `RBD_ASSERT_NOW(a_busy_when_out, clk, rst, dst.valid, !src.ready, "input taken while a word is pending")
  `RBD_ASSERT_NOW(a_cnt_range, clk, rst, dst.valid, dst.out_count <= CNT_W'(OUT_LANES), "word count exceeds lanes")
  `RBD_ASSERT_NOW(a_status_only_last, clk, rst, dst.valid && dst.out_count == '0, dst.item_last, "status-only word not last")
  `RBD_ASSERT_NEXT(a_busy_after_take, clk, rst, src.valid && src.ready, !src.ready && !dst.valid, "sequencer skipped decode")

endmodule

`default_nettype wire
